// ===== hw/rtl/tbfm_pkg.sv =====
// Shared types, constants and helpers for the triple-buffer frame manager.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package tbfm_pkg;

  // Slot bookkeeping
  localparam int SLOT_COUNT = 3;
  localparam int SLOT_W     = 2;
  localparam logic [SLOT_W-1:0] NO_SLOT = 2'd3;

  // Field widths
  localparam int KIND_W   = 3;
  localparam int LEN_W    = 24;
  localparam int TIME_W   = 48;
  localparam int CNT_W    = 32;
  localparam int RATE_W   = 16;
  localparam int REG_W    = 32;
  localparam int PROD_W   = 2 * CNT_W;
  localparam int FRAC_W   = 8;
  localparam int CFG_IDX_W = 1;

  // Command kinds of an input item
  localparam logic [KIND_W-1:0] KIND_CLAIM       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_COMMIT      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACQUIRE     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DROP        = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESET_STATS = 3'd4;
  localparam logic [KIND_W-1:0] KIND_CLEAR       = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RECONFIG    = 3'd6;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SEC = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECENT_WINDOW = 1'd1;

  // Configuration reset values
  localparam logic [REG_W-1:0] TICKS_PER_SEC_RST = 32'd10000000;
  localparam logic [REG_W-1:0] RECENT_WINDOW_RST = 32'd10000000;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;     // latch the input item
    logic execute;     // apply the item to the state
    logic mul;         // form frames * ticks product
    logic div_start;   // launch the rate divider
    logic rate_wr;     // store the divider result as the rate
    logic out_load;    // load the result register
  } tbfm_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_rate;   // current commit closes the rate window
    logic div_done;    // divider result ready
  } tbfm_stat_t;

  // Lowest slot that is neither pending nor held
  function automatic logic [SLOT_W-1:0] pick_free(input logic [SLOT_W-1:0] pend,
                                                  input logic [SLOT_W-1:0] held);
    logic [SLOT_W-1:0] res;
    res = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (SLOT_W'(i) != pend && SLOT_W'(i) != held) begin
        res = SLOT_W'(i);
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tbfm_div.sv =====
// Restoring serial divider for the frame rate: floor(num * 256 / den), saturated.
// Uses tbfm_pkg for widths; one quotient bit per cycle.
`default_nettype none

module tbfm_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic [tbfm_pkg::PROD_W-1:0] num,
  input  wire logic [tbfm_pkg::TIME_W-1:0] den,
  output logic                             done,
  output logic [tbfm_pkg::RATE_W-1:0]      quot
);

  localparam int CW = $clog2(tbfm_pkg::RATE_W);
  localparam int TW = tbfm_pkg::TIME_W;

  logic            busy_r;
  logic            done_r;
  logic [CW-1:0]   cnt_r;
  logic            ovf_r;
  logic [TW-1:0]   rem_r;
  logic [TW-1:0]   den_r;
  logic [tbfm_pkg::RATE_W-1:0] sh_r;
  logic [tbfm_pkg::RATE_W-1:0] q_r;

  logic [TW:0]     cand;
  logic            ge;
  logic [TW-1:0]   diff;
  logic [TW-1:0]   rem_nxt;

  // Trial subtract for one quotient bit; a kept difference is below den
  assign cand    = {rem_r, sh_r[tbfm_pkg::RATE_W-1]};
  assign ge      = cand >= {1'b0, den_r};
  assign diff    = cand[TW-1:0] - den_r;
  assign rem_nxt = ge ? diff : cand[TW-1:0];

  // Sequence control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(tbfm_pkg::RATE_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift; the high part of the dividend seeds the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      ovf_r <= num >= {den, {tbfm_pkg::FRAC_W{1'b0}}};
      rem_r <= num[tbfm_pkg::FRAC_W +: TW];
      den_r <= den;
      sh_r  <= {num[tbfm_pkg::FRAC_W-1:0], {(tbfm_pkg::RATE_W - tbfm_pkg::FRAC_W){1'b0}}};
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      sh_r  <= {sh_r[tbfm_pkg::RATE_W-2:0], 1'b0};
      q_r   <= {q_r[tbfm_pkg::RATE_W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quot = ovf_r ? {tbfm_pkg::RATE_W{1'b1}} : q_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tbfm_dp.sv =====
// Datapath of the frame manager: slot state, counters, rate window, result register.
// Uses tbfm_pkg and instantiates tbfm_div; driven by tbfm_ctrl commands.
`default_nettype none

module tbfm_dp (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire tbfm_pkg::tbfm_cmd_t            cmd,
  output tbfm_pkg::tbfm_stat_t                stat,
  input  wire logic                           cfg_we,
  input  wire logic [tbfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tbfm_pkg::REG_W-1:0]     cfg_data,
  input  wire logic [tbfm_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [tbfm_pkg::LEN_W-1:0]     in_frame_length,
  input  wire logic [tbfm_pkg::TIME_W-1:0]    in_now,
  output logic [tbfm_pkg::SLOT_W-1:0]         out_write_slot,
  output logic                                out_is_new,
  output logic                                out_read_valid,
  output logic [tbfm_pkg::SLOT_W-1:0]         out_read_slot,
  output logic [tbfm_pkg::LEN_W-1:0]          out_read_size,
  output logic [tbfm_pkg::CNT_W-1:0]          out_read_sequence,
  output logic [tbfm_pkg::CNT_W-1:0]          out_received_count,
  output logic [tbfm_pkg::CNT_W-1:0]          out_dropped_count,
  output logic [tbfm_pkg::CNT_W-1:0]          out_displayed_count,
  output logic [tbfm_pkg::RATE_W-1:0]         out_rate_fixed,
  output logic                                out_recent
);

  localparam int TW = tbfm_pkg::TIME_W;
  localparam int CW = tbfm_pkg::CNT_W;
  localparam int SW = tbfm_pkg::SLOT_W;

  // Configuration
  logic [tbfm_pkg::REG_W-1:0] tps_r;
  logic [tbfm_pkg::REG_W-1:0] rwin_r;

  // Latched item
  logic [tbfm_pkg::KIND_W-1:0] kind_r;
  logic [tbfm_pkg::LEN_W-1:0]  len_r;
  logic [TW-1:0]               now_r;

  // Architectural state
  logic [SW-1:0]               pend_r;
  logic [SW-1:0]               held_r;
  logic [SW-1:0]               claim_r;
  logic [tbfm_pkg::LEN_W-1:0]  sizes_r [tbfm_pkg::SLOT_COUNT];
  logic [CW-1:0]               seq_r;
  logic [CW-1:0]               held_seq_r;
  logic [CW-1:0]               recv_r;
  logic [CW-1:0]               drop_r;
  logic [CW-1:0]               disp_r;
  logic [TW-1:0]               last_r;
  logic [TW-1:0]               ws_r;
  logic [CW-1:0]               wf_r;
  logic [tbfm_pkg::RATE_W-1:0] rate_r;
  logic                        is_new_r;

  // Rate computation operands
  logic [CW-1:0]               frames_r;
  logic [tbfm_pkg::REG_W-1:0]  tps_lat_r;
  logic [TW-1:0]               elapsed_r;
  logic [tbfm_pkg::PROD_W-1:0] prod_r;

  logic [tbfm_pkg::REG_W-1:0]  tps_eff;
  logic [TW-1:0]               ws_eff;
  logic [CW-1:0]               wf_eff;
  logic [TW-1:0]               elapsed;
  logic                        close_win;
  logic                        div_done;
  logic [tbfm_pkg::RATE_W-1:0] div_quot;

  logic                        rd_valid;
  logic [tbfm_pkg::LEN_W-1:0]  rd_size;
  logic [TW-1:0]               age;
  logic                        recent;

  // Rate window bookkeeping for a commit
  assign tps_eff   = (tps_r == '0) ? tbfm_pkg::REG_W'(1) : tps_r;
  assign ws_eff    = (ws_r == '0) ? now_r : ws_r;
  assign wf_eff    = ((ws_r == '0) ? '0 : wf_r) + 1'b1;
  assign elapsed   = now_r - ws_eff;
  assign close_win = (now_r >= ws_eff) && (elapsed >= TW'(tps_eff));

  assign stat.need_rate = (kind_r == tbfm_pkg::KIND_COMMIT) && close_win;
  assign stat.div_done  = div_done;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r  <= tbfm_pkg::TICKS_PER_SEC_RST;
      rwin_r <= tbfm_pkg::RECENT_WINDOW_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tbfm_pkg::CFG_TICKS_PER_SEC: tps_r  <= cfg_data;
        tbfm_pkg::CFG_RECENT_WINDOW: rwin_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the accepted item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      len_r  <= in_frame_length;
      now_r  <= in_now;
    end
  end

  // Apply the item to the frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r     <= tbfm_pkg::NO_SLOT;
      held_r     <= tbfm_pkg::NO_SLOT;
      claim_r    <= '0;
      for (int i = 0; i < tbfm_pkg::SLOT_COUNT; i++) sizes_r[i] <= '0;
      seq_r      <= '0;
      held_seq_r <= '0;
      recv_r     <= '0;
      drop_r     <= '0;
      disp_r     <= '0;
      last_r     <= '0;
      ws_r       <= '0;
      wf_r       <= '0;
      rate_r     <= '0;
      is_new_r   <= 1'b0;
    end else if (cmd.execute) begin
      is_new_r <= 1'b0;
      unique case (kind_r)
        tbfm_pkg::KIND_CLAIM: begin
          claim_r <= tbfm_pkg::pick_free(pend_r, held_r);
        end
        tbfm_pkg::KIND_COMMIT: begin
          if (pend_r != tbfm_pkg::NO_SLOT) drop_r <= drop_r + 1'b1;
          if (claim_r < SW'(tbfm_pkg::SLOT_COUNT)) sizes_r[claim_r] <= len_r;
          pend_r <= claim_r;
          seq_r  <= seq_r + 1'b1;
          recv_r <= recv_r + 1'b1;
          last_r <= now_r;
          if (close_win) begin
            ws_r <= now_r;
            wf_r <= '0;
          end else begin
            ws_r <= ws_eff;
            wf_r <= wf_eff;
          end
        end
        tbfm_pkg::KIND_ACQUIRE: begin
          if (pend_r != tbfm_pkg::NO_SLOT) begin
            held_r     <= pend_r;
            pend_r     <= tbfm_pkg::NO_SLOT;
            held_seq_r <= seq_r;
            disp_r     <= disp_r + 1'b1;
            is_new_r   <= 1'b1;
          end
        end
        tbfm_pkg::KIND_DROP: begin
          pend_r <= tbfm_pkg::NO_SLOT;
        end
        tbfm_pkg::KIND_RESET_STATS: begin
          recv_r <= '0;
          drop_r <= '0;
          disp_r <= '0;
          rate_r <= '0;
          ws_r   <= '0;
          wf_r   <= '0;
        end
        tbfm_pkg::KIND_CLEAR: begin
          pend_r <= tbfm_pkg::NO_SLOT;
          held_r <= tbfm_pkg::NO_SLOT;
        end
        tbfm_pkg::KIND_RECONFIG: begin
          pend_r     <= tbfm_pkg::NO_SLOT;
          held_r     <= tbfm_pkg::NO_SLOT;
          claim_r    <= '0;
          for (int i = 0; i < tbfm_pkg::SLOT_COUNT; i++) sizes_r[i] <= '0;
          seq_r      <= '0;
          held_seq_r <= '0;
          recv_r     <= '0;
          drop_r     <= '0;
          disp_r     <= '0;
          last_r     <= '0;
          ws_r       <= '0;
          wf_r       <= '0;
          rate_r     <= '0;
        end
        default: ;
      endcase
    end else if (cmd.rate_wr) begin
      rate_r <= div_quot;
    end
  end

  // Hold the rate operands of a closing window
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      frames_r  <= wf_eff;
      tps_lat_r <= tps_eff;
      elapsed_r <= elapsed;
    end
    if (cmd.mul) begin
      prod_r <= tbfm_pkg::PROD_W'(frames_r) * tbfm_pkg::PROD_W'(tps_lat_r);
    end
  end

  tbfm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (prod_r),
    .den   (elapsed_r),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Read-side view of the held slot
  assign rd_valid = held_r < SW'(tbfm_pkg::SLOT_COUNT);
  always_comb begin
    case (held_r)
      2'd0:    rd_size = sizes_r[0];
      2'd1:    rd_size = sizes_r[1];
      2'd2:    rd_size = sizes_r[2];
      default: rd_size = '0;
    endcase
  end

  // Recent arrival flag against the item's timestamp
  assign age    = now_r - last_r;
  assign recent = (last_r != '0) && ((now_r < last_r) || (age <= TW'(rwin_r)));

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_write_slot      <= claim_r;
      out_is_new          <= is_new_r;
      out_read_valid      <= rd_valid;
      out_read_slot       <= rd_valid ? held_r : '0;
      out_read_size       <= rd_size;
      out_read_sequence   <= rd_valid ? held_seq_r : '0;
      out_received_count  <= recv_r;
      out_dropped_count   <= drop_r;
      out_displayed_count <= disp_r;
      out_rate_fixed      <= rate_r;
      out_recent          <= recent;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tbfm_ctrl.sv =====
// Controller of the frame manager: sequences capture, update, rate division, result.
// Uses tbfm_pkg command and status types; pairs with tbfm_dp.
`default_nettype none

module tbfm_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire tbfm_pkg::tbfm_stat_t stat,
  output tbfm_pkg::tbfm_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_MUL      = 3'd2;
  localparam logic [2:0] S_DIV_GO   = 3'd3;
  localparam logic [2:0] S_DIV_WAIT = 3'd4;
  localparam logic [2:0] S_FIN      = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       ovalid_r;
  logic       ovalid_nxt;
  logic       out_free;

  assign out_free = !ovalid_r || !out_stall;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.capture = in_valid;
        if (in_valid) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.execute = 1'b1;
        state_nxt   = stat.need_rate ? S_MUL : S_FIN;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.rate_wr = 1'b1;
          state_nxt   = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Result valid: set on load, drop once taken
  always_comb begin
    ovalid_nxt = ovalid_r;
    if (cmd.out_load) begin
      ovalid_nxt = 1'b1;
    end else if (ovalid_r && !out_stall) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = ovalid_r;

endmodule

`default_nettype wire

// ===== hw/rtl/triple_buffer_frame_manager.sv =====
// Top level of the triple-buffer frame manager: controller, datapath, config port.
// Depends on tbfm_pkg, tbfm_ctrl, tbfm_dp (which holds tbfm_div).
//
// Usage:
//  - Input channel (in_valid / in_stall): one command item with kind, frame length
//    and timestamp. An item is taken when in_valid is high and in_stall is low.
//  - Result channel (out_valid / out_stall): exactly one status item per command,
//    showing slots, frame size and sequence, counters, rate (8.8) and recent flag.
//  - Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): index 0 is ticks
//    per second, index 1 the recent window. cfg_ready is always high; write only
//    while no command is in flight.
//  - Sequence: an accepted item is captured, applied to the state, then loaded
//    into the result register. A commit that closes the one-second rate window
//    adds a multiply and a 16-step serial divide before the load.
//  - in_stall stays high until the previous item's result is loaded: one item at a time.
//  - A finished result waits in the output register; the next item is accepted
//    while it waits, and its result is held until the register frees up.
//  - Reset (rst_n low, synchronous): slots none pending or held, counters and
//    rate zero, configuration at 10000000 ticks for both registers.
`default_nettype none

module triple_buffer_frame_manager (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [tbfm_pkg::KIND_W-1:0]    in_kind,
  input  wire logic [tbfm_pkg::LEN_W-1:0]     in_frame_length,
  input  wire logic [tbfm_pkg::TIME_W-1:0]    in_now,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [tbfm_pkg::SLOT_W-1:0]         out_write_slot,
  output logic                                out_is_new,
  output logic                                out_read_valid,
  output logic [tbfm_pkg::SLOT_W-1:0]         out_read_slot,
  output logic [tbfm_pkg::LEN_W-1:0]          out_read_size,
  output logic [tbfm_pkg::CNT_W-1:0]          out_read_sequence,
  output logic [tbfm_pkg::CNT_W-1:0]          out_received_count,
  output logic [tbfm_pkg::CNT_W-1:0]          out_dropped_count,
  output logic [tbfm_pkg::CNT_W-1:0]          out_displayed_count,
  output logic [tbfm_pkg::RATE_W-1:0]         out_rate_fixed,
  output logic                                out_recent,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [tbfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [tbfm_pkg::REG_W-1:0]     cfg_data
);

  tbfm_pkg::tbfm_cmd_t  cmd;
  tbfm_pkg::tbfm_stat_t stat;

  // Config writes are never held off; each is registered directly
  assign cfg_ready = 1'b1;

  tbfm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  tbfm_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .cfg_we              (cfg_valid & cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_kind             (in_kind),
    .in_frame_length     (in_frame_length),
    .in_now              (in_now),
    .out_write_slot      (out_write_slot),
    .out_is_new          (out_is_new),
    .out_read_valid      (out_read_valid),
    .out_read_slot       (out_read_slot),
    .out_read_size       (out_read_size),
    .out_read_sequence   (out_read_sequence),
    .out_received_count  (out_received_count),
    .out_dropped_count   (out_dropped_count),
    .out_displayed_count (out_displayed_count),
    .out_rate_fixed      (out_rate_fixed),
    .out_recent          (out_recent)
  );

endmodule

`default_nettype wire
